// ===== rtl/rpt_pkg.sv =====
// Package for the regex pattern tokenizer.
// Holds the parse mode type, token and error codes, byte constants and bitmap helpers.
// No dependencies.
package rpt_pkg;

  localparam int IDX_W = 10;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CLASS  = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

  localparam logic [2:0] KIND_CLASS  = 3'd0;
  localparam logic [2:0] KIND_OP     = 3'd1;
  localparam logic [2:0] KIND_LPAREN = 3'd2;
  localparam logic [2:0] KIND_RPAREN = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [3:0] ERR_OK        = 4'd0;
  localparam logic [3:0] ERR_TRAIL_ESC = 4'd1;
  localparam logic [3:0] ERR_RPAREN    = 4'd2;
  localparam logic [3:0] ERR_OPEN_CLS  = 4'd3;
  localparam logic [3:0] ERR_EMPTY_CLS = 4'd4;
  localparam logic [3:0] ERR_RBRACKET  = 4'd5;
  localparam logic [3:0] ERR_RANGE     = 4'd6;
  localparam logic [3:0] ERR_LPAREN    = 4'd7;
  localparam logic [3:0] ERR_RESERVED  = 4'd8;
  localparam logic [3:0] ERR_STACK     = 4'd9;
  localparam logic [3:0] ERR_SYMBOLS   = 4'd10;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_US    = 8'h5f;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUES  = 8'h3f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_MAX   = 8'hff;

  typedef struct packed {
    logic              tok;
    logic [2:0]        kind;
    logic [255:0]      bits;
    logic [7:0]        op;
    logic [IDX_W-1:0]  idx;
    logic              stat;
    logic [3:0]        err;
    logic [IDX_W-1:0]  stat_idx;
  } rec_t;

  function automatic logic [255:0] one_hot(input logic [7:0] c);
    one_hot = 256'(1) << c;
  endfunction

  function automatic logic [255:0] range_mask(input logic [7:0] lo, input logic [7:0] hi,
                                              input logic [7:0] ex);
    range_mask = ({256{1'b1}} << lo) & ({256{1'b1}} >> (~hi)) & ~one_hot(ex);
  endfunction

endpackage

// ===== rtl/rpt_stack_mem.sv =====
// Paren stack memory of the regex pattern tokenizer.
// One write port and one registered read port; depends on nothing.
module rpt_stack_mem #(
  parameter int DEPTH  = 16,
  parameter int AW     = 4,
  parameter int DW     = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rpt_parser.sv =====
// Byte parser of the regex pattern tokenizer: mode, class bitmap, counters.
// Uses rpt_pkg; drives the paren stack memory ports and a result record per beat.
module rpt_parser
  import rpt_pkg::*;
#(
  parameter int PAREN_DEPTH = 16,
  parameter int MAX_SYMBOLS = 1024,
  parameter int AW          = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  logic          accept,
  input  logic [7:0]    pattern_byte,
  input  logic          end_of_pattern,
  output rec_t          rec,
  output logic          push,
  output logic [AW-1:0] push_addr,
  output logic [IDX_W-1:0] push_data,
  output logic          pop,
  output logic [AW-1:0] pop_addr
);

  localparam int CW  = $clog2(MAX_SYMBOLS + 1);
  localparam int SPW = $clog2(PAREN_DEPTH + 1);

  logic [7:0]     excluded;
  mode_t          mode, mode_next;
  logic [255:0]   acc, acc_next;
  logic [7:0]     pend, pend_next;
  logic           pend_ok, pend_ok_next;
  logic           dash, dash_next;
  logic           empty, empty_next;
  logic [CW-1:0]  count, count_next;
  logic [SPW-1:0] sp, sp_next, sp_dec;

  logic           tok;
  logic [2:0]     kind;
  logic [7:0]     op;
  logic [3:0]     err;
  logic [255:0]   bits;
  logic           do_push, do_pop;
  logic [7:0]     b;

  assign b      = pattern_byte;
  assign sp_dec = sp - 1'b1;

  always_comb begin
    mode_next    = mode;
    acc_next     = acc;
    pend_next    = pend;
    pend_ok_next = pend_ok;
    dash_next    = dash;
    empty_next   = empty;
    count_next   = count;
    sp_next      = sp;
    tok          = 1'b0;
    kind         = KIND_CLASS;
    op           = '0;
    err          = ERR_OK;
    bits         = '0;
    do_push      = 1'b0;
    do_pop       = 1'b0;
    rec          = '0;
    unique case (mode)
      MODE_DROP: begin
      end
      MODE_ESC: begin
        mode_next = MODE_NORMAL;
        tok       = 1'b1;
        if (b == CH_D) begin
          bits = range_mask(CH_0, CH_9, excluded);
        end else if (b == CH_W) begin
          bits = range_mask(CH_UA, CH_UZ, excluded) | range_mask(CH_LA, CH_LZ, excluded)
               | range_mask(CH_0, CH_9, excluded) | one_hot(CH_US);
          if (excluded == CH_US) err = ERR_RESERVED;
        end else begin
          bits = one_hot(b);
          if (b == excluded) err = ERR_RESERVED;
        end
      end
      MODE_CLASS: begin
        if (b == CH_RBRK) begin
          if (empty) begin
            err = ERR_EMPTY_CLS;
          end else begin
            if (pend_ok && pend == excluded) err = ERR_RESERVED;
            else if (dash && excluded == CH_DASH) err = ERR_RESERVED;
            bits = acc | (pend_ok ? one_hot(pend) : '0) | (dash ? one_hot(CH_DASH) : '0);
            acc_next  = bits;
            tok       = 1'b1;
            mode_next = MODE_NORMAL;
          end
        end else begin
          empty_next = 1'b0;
          if (dash) begin
            if (pend > b) err = ERR_RANGE;
            else acc_next = acc | range_mask(pend, b, excluded);
            pend_ok_next = 1'b0;
            dash_next    = 1'b0;
          end else if (pend_ok && b == CH_DASH) begin
            dash_next = 1'b1;
          end else begin
            if (pend_ok) begin
              if (pend == excluded) err = ERR_RESERVED;
              else acc_next = acc | one_hot(pend);
            end
            pend_next    = b;
            pend_ok_next = 1'b1;
          end
        end
      end
      default: begin
        case (b)
          CH_BSL: mode_next = MODE_ESC;
          CH_QUES, CH_STAR, CH_PLUS, CH_BAR: begin
            tok  = 1'b1;
            kind = KIND_OP;
            op   = b;
          end
          CH_DOT: begin
            tok  = 1'b1;
            bits = range_mask(8'h00, CH_MAX, excluded);
          end
          CH_LPAR: begin
            if (sp >= SPW'(PAREN_DEPTH)) begin
              err = ERR_STACK;
            end else begin
              do_push = 1'b1;
              sp_next = sp + 1'b1;
              tok     = 1'b1;
              kind    = KIND_LPAREN;
            end
          end
          CH_RPAR: begin
            if (sp == '0) begin
              err = ERR_RPAREN;
            end else begin
              do_pop  = 1'b1;
              sp_next = sp_dec;
              tok     = 1'b1;
              kind    = KIND_RPAREN;
            end
          end
          CH_LBRK: begin
            mode_next    = MODE_CLASS;
            acc_next     = '0;
            pend_next    = '0;
            pend_ok_next = 1'b0;
            dash_next    = 1'b0;
            empty_next   = 1'b1;
          end
          CH_RBRK: err = ERR_RBRACKET;
          default: begin
            tok  = 1'b1;
            bits = one_hot(b);
            if (b == excluded) err = ERR_RESERVED;
          end
        endcase
      end
    endcase

    if (err != ERR_OK) tok = 1'b0;
    if (tok) begin
      if (count >= CW'(MAX_SYMBOLS)) begin
        err = ERR_SYMBOLS;
        tok = 1'b0;
      end else begin
        count_next = count + 1'b1;
      end
    end

    if (mode != MODE_DROP && err == ERR_OK && end_of_pattern) begin
      if (mode_next == MODE_ESC) err = ERR_TRAIL_ESC;
      else if (mode_next == MODE_CLASS) err = ERR_OPEN_CLS;
      else if (sp_next != '0) err = ERR_LPAREN;
    end

    rec.tok      = tok;
    rec.kind     = kind;
    rec.bits     = (kind == KIND_CLASS) ? bits : '0;
    rec.op       = op;
    rec.idx      = IDX_W'(count);
    rec.stat     = (mode != MODE_DROP) && (err != ERR_OK || end_of_pattern);
    rec.err      = err;
    rec.stat_idx = IDX_W'(count_next);

    if (end_of_pattern) begin
      mode_next    = MODE_NORMAL;
      acc_next     = '0;
      pend_next    = '0;
      pend_ok_next = 1'b0;
      dash_next    = 1'b0;
      empty_next   = 1'b1;
      count_next   = '0;
      sp_next      = '0;
    end else if (err != ERR_OK) begin
      mode_next = MODE_DROP;
    end
  end

  assign push      = accept && do_push;
  assign push_addr = sp[AW-1:0];
  assign push_data = IDX_W'(count);
  assign pop       = accept && do_pop;
  assign pop_addr  = sp_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      excluded <= '0;
    end else if (cfg_we) begin
      excluded <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      acc     <= '0;
      pend    <= '0;
      pend_ok <= 1'b0;
      dash    <= 1'b0;
      empty   <= 1'b1;
      count   <= '0;
      sp      <= '0;
    end else if (accept) begin
      mode    <= mode_next;
      acc     <= acc_next;
      pend    <= pend_next;
      pend_ok <= pend_ok_next;
      dash    <= dash_next;
      empty   <= empty_next;
      count   <= count_next;
      sp      <= sp_next;
    end
  end

endmodule

// ===== rtl/regex_pattern_tokenizer.sv =====
// Regex pattern tokenizer, top level.
// Channels: the input beat carries pattern_byte and end_of_pattern on in_valid and
// in_ready; each output beat carries one token or status result on out_valid and
// out_ready, with last_of_run high on the last result of a byte.
// The user writes excluded_byte via excluded_byte_we only while idle; not enforced.
// A byte is parsed in the cycle it is accepted; the paren stack memory read issued then
// returns the partner index in the next cycle; results pass the parsed stage and output
// register. One byte is taken per cycle unless the output stalls; a byte that yields
// a token and a status result takes two beats, set by the single result register.
// Reset clears the mode, class bitmap, counters, stack pointer and excluded_byte; the
// stack memory needs no clearing since only entries below the pointer are read.
// When the receiver stalls, the output register and one parsed stage fill, and then
// in_ready drops until the output drains.
module regex_pattern_tokenizer
  import rpt_pkg::*;
#(
  parameter int PAREN_DEPTH = 16,
  parameter int MAX_SYMBOLS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        excluded_byte_we,
  input  logic [7:0]  excluded_byte,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pattern_byte,
  input  logic        end_of_pattern,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  symbol_kind,
  output logic [63:0] class_bits_0,
  output logic [63:0] class_bits_1,
  output logic [63:0] class_bits_2,
  output logic [63:0] class_bits_3,
  output logic [7:0]  operator_char,
  output logic [9:0]  symbol_index,
  output logic [9:0]  partner_index,
  output logic [3:0]  error_code,
  output logic        last_of_run
);

  localparam int AW = (PAREN_DEPTH > 1) ? $clog2(PAREN_DEPTH) : 1;

  rec_t             prec, s1_rec, o_rec;
  logic             s1_valid, o_valid, o_tok_done;
  logic [IDX_W-1:0] o_partner, rdata, push_data;
  logic             push, pop, accept, fire, show_tok, o_last, o_free, move;
  logic [AW-1:0]    push_addr, pop_addr;

  rpt_parser #(
    .PAREN_DEPTH (PAREN_DEPTH),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .AW          (AW)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (excluded_byte_we),
    .cfg_data       (excluded_byte),
    .accept         (accept),
    .pattern_byte   (pattern_byte),
    .end_of_pattern (end_of_pattern),
    .rec            (prec),
    .push           (push),
    .push_addr      (push_addr),
    .push_data      (push_data),
    .pop            (pop),
    .pop_addr       (pop_addr)
  );

  rpt_stack_mem #(
    .DEPTH (PAREN_DEPTH),
    .AW    (AW),
    .DW    (IDX_W)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (push_addr),
    .wdata (push_data),
    .re    (pop),
    .raddr (pop_addr),
    .rdata (rdata)
  );

  assign show_tok = o_rec.tok && !o_tok_done;
  assign fire     = o_valid && out_ready;
  assign o_last   = show_tok ? !o_rec.stat : 1'b1;
  assign o_free   = !o_valid || (fire && o_last);
  assign move     = s1_valid && o_free;
  assign in_ready = !s1_valid || o_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rec <= prec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      o_tok_done <= 1'b0;
    end else if (move) begin
      o_valid    <= s1_rec.tok || s1_rec.stat;
      o_tok_done <= 1'b0;
    end else if (fire) begin
      if (o_last) begin
        o_valid <= 1'b0;
      end else begin
        o_tok_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      o_rec     <= s1_rec;
      o_partner <= rdata;
    end
  end

  assign out_valid     = o_valid;
  assign symbol_kind   = show_tok ? o_rec.kind : KIND_STATUS;
  assign class_bits_0  = show_tok ? o_rec.bits[63:0] : '0;
  assign class_bits_1  = show_tok ? o_rec.bits[127:64] : '0;
  assign class_bits_2  = show_tok ? o_rec.bits[191:128] : '0;
  assign class_bits_3  = show_tok ? o_rec.bits[255:192] : '0;
  assign operator_char = show_tok ? o_rec.op : '0;
  assign symbol_index  = show_tok ? o_rec.idx : o_rec.stat_idx;
  assign partner_index = (show_tok && o_rec.kind == KIND_RPAREN) ? o_partner : '0;
  assign error_code    = show_tok ? ERR_OK : o_rec.err;
  assign last_of_run   = o_last;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the regex pattern tokenizer: random and directed pattern bytes,
// tokens predicted in the bench and checked beat by beat by a small scoreboard.
// Depends on rpt_pkg and regex_pattern_tokenizer.
`timescale 1ns / 100ps

class token_scoreboard;
  typedef struct packed {
    logic [2:0]   kind;
    logic [255:0] bits;
    logic [7:0]   op;
    logic [9:0]   idx;
    logic [9:0]   partner;
    logic [3:0]   err;
    logic         last;
  } token_t;

  token_t       pending_tokens[$];
  int           errors;
  logic [7:0]   excl;
  rpt_pkg::mode_t mode;
  logic [255:0] acc;
  logic [7:0]   pch;
  bit           pvalid, dash, empty;
  int           count;
  logic [9:0]   stack[16];
  int           sp;

  function new();
    errors = 0;
    excl = '0;
    clear();
  endfunction

  function void clear();
    mode = rpt_pkg::MODE_NORMAL;
    acc = '0;
    pch = '0;
    pvalid = 0;
    dash = 0;
    empty = 1;
    count = 0;
    sp = 0;
  endfunction

  function bit put_char(ref logic [255:0] b, input logic [7:0] c);
    if (c == excl) return 0;
    b[c] = 1'b1;
    return 1;
  endfunction

  function bit put_range(ref logic [255:0] b, input int lo, input int hi);
    if (lo > hi) return 0;
    for (int i = lo; i <= hi; i++) if (i != excl) b[i] = 1'b1;
    return 1;
  endfunction

  function void push(logic [2:0] k, logic [255:0] b, logic [7:0] o, int i, logic [9:0] p,
                     logic [3:0] e);
    token_t t;
    t.kind = k; t.bits = b; t.op = o; t.idx = i[9:0]; t.partner = p; t.err = e;
    t.last = 0;
    pending_tokens.push_back(t);
  endfunction

  function void note_byte(logic [7:0] b, bit last);
    logic [255:0] bits;
    bit tok;
    logic [2:0] kind;
    logic [7:0] op;
    logic [9:0] partner;
    logic [3:0] err;
    int n0;
    bits = '0; tok = 0; kind = rpt_pkg::KIND_CLASS; op = '0; partner = '0;
    err = rpt_pkg::ERR_OK;
    n0 = pending_tokens.size();
    if (mode == rpt_pkg::MODE_DROP) begin
      if (last) clear();
      return;
    end
    if (mode == rpt_pkg::MODE_ESC) begin
      mode = rpt_pkg::MODE_NORMAL;
      tok = 1;
      if (b == rpt_pkg::CH_D) void'(put_range(bits, rpt_pkg::CH_0, rpt_pkg::CH_9));
      else if (b == rpt_pkg::CH_W) begin
        void'(put_range(bits, rpt_pkg::CH_UA, rpt_pkg::CH_UZ));
        void'(put_range(bits, rpt_pkg::CH_LA, rpt_pkg::CH_LZ));
        void'(put_range(bits, rpt_pkg::CH_0, rpt_pkg::CH_9));
        if (!put_char(bits, rpt_pkg::CH_US)) err = rpt_pkg::ERR_RESERVED;
      end else if (!put_char(bits, b)) err = rpt_pkg::ERR_RESERVED;
    end else if (mode == rpt_pkg::MODE_CLASS) begin
      if (b == rpt_pkg::CH_RBRK) begin
        if (empty) err = rpt_pkg::ERR_EMPTY_CLS;
        else begin
          if (pvalid && !put_char(acc, pch)) err = rpt_pkg::ERR_RESERVED;
          if (err == rpt_pkg::ERR_OK && dash && !put_char(acc, rpt_pkg::CH_DASH))
            err = rpt_pkg::ERR_RESERVED;
          bits = acc;
          tok = 1;
          mode = rpt_pkg::MODE_NORMAL;
        end
      end else begin
        empty = 0;
        if (dash) begin
          if (!put_range(acc, pch, b)) err = rpt_pkg::ERR_RANGE;
          pvalid = 0;
          dash = 0;
        end else if (pvalid && b == rpt_pkg::CH_DASH) dash = 1;
        else begin
          if (pvalid && !put_char(acc, pch)) err = rpt_pkg::ERR_RESERVED;
          pch = b;
          pvalid = 1;
        end
      end
    end else begin
      case (b)
        rpt_pkg::CH_BSL: mode = rpt_pkg::MODE_ESC;
        rpt_pkg::CH_QUES, rpt_pkg::CH_STAR, rpt_pkg::CH_PLUS, rpt_pkg::CH_BAR: begin
          tok = 1; kind = rpt_pkg::KIND_OP; op = b;
        end
        rpt_pkg::CH_DOT: begin
          tok = 1; void'(put_range(bits, 0, 255));
        end
        rpt_pkg::CH_LPAR: begin
          if (sp >= 16) err = rpt_pkg::ERR_STACK;
          else begin
            stack[sp] = count[9:0]; sp++; tok = 1; kind = rpt_pkg::KIND_LPAREN;
          end
        end
        rpt_pkg::CH_RPAR: begin
          if (sp == 0) err = rpt_pkg::ERR_RPAREN;
          else begin
            sp--; partner = stack[sp]; tok = 1; kind = rpt_pkg::KIND_RPAREN;
          end
        end
        rpt_pkg::CH_LBRK: begin
          mode = rpt_pkg::MODE_CLASS; acc = '0; pch = '0; pvalid = 0; dash = 0; empty = 1;
        end
        rpt_pkg::CH_RBRK: err = rpt_pkg::ERR_RBRACKET;
        default: begin
          tok = 1;
          if (!put_char(bits, b)) err = rpt_pkg::ERR_RESERVED;
        end
      endcase
    end
    if (err == rpt_pkg::ERR_OK && tok) begin
      if (count >= 1024) err = rpt_pkg::ERR_SYMBOLS;
      else begin
        push(kind, kind == rpt_pkg::KIND_CLASS ? bits : '0, op, count, partner,
             rpt_pkg::ERR_OK);
        count++;
      end
    end
    if (err == rpt_pkg::ERR_OK && last) begin
      if (mode == rpt_pkg::MODE_ESC) err = rpt_pkg::ERR_TRAIL_ESC;
      else if (mode == rpt_pkg::MODE_CLASS) err = rpt_pkg::ERR_OPEN_CLS;
      else if (sp > 0) err = rpt_pkg::ERR_LPAREN;
    end
    if (err != rpt_pkg::ERR_OK || last) begin
      push(rpt_pkg::KIND_STATUS, '0, '0, count, '0, err);
      if (last) clear();
      else mode = rpt_pkg::MODE_DROP;
    end
    if (pending_tokens.size() > n0) pending_tokens[$].last = 1;
  endfunction

  function void check_token(token_t got);
    token_t want;
    if (pending_tokens.size() == 0) begin
      $display("%0t: unexpected beat, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_tokens.pop_front();
    if (got.kind != want.kind) report("symbol_kind", want.kind, got.kind);
    if (got.bits[63:0] != want.bits[63:0])
      report("class_bits_0", want.bits[63:0], got.bits[63:0]);
    if (got.bits[127:64] != want.bits[127:64])
      report("class_bits_1", want.bits[127:64], got.bits[127:64]);
    if (got.bits[191:128] != want.bits[191:128])
      report("class_bits_2", want.bits[191:128], got.bits[191:128]);
    if (got.bits[255:192] != want.bits[255:192])
      report("class_bits_3", want.bits[255:192], got.bits[255:192]);
    if (got.op != want.op) report("operator_char", want.op, got.op);
    if (got.idx != want.idx) report("symbol_index", want.idx, got.idx);
    if (got.partner != want.partner) report("partner_index", want.partner, got.partner);
    if (got.err != want.err) report("error_code", want.err, got.err);
    if (got.last != want.last) report("last_of_run", want.last, got.last);
  endfunction

  function void report(string f, logic [63:0] w, logic [63:0] a);
    $display("%0t: %s expected %h actual %h", $time, f, w, a);
    errors++;
  endfunction
endclass

module tb_top;
  import rpt_pkg::*;

  logic clk = 0, rst = 1;
  logic excluded_byte_we = 0;
  logic [7:0] excluded_byte = 0;
  logic in_valid = 0, in_ready;
  logic [7:0] pattern_byte = 0;
  logic end_of_pattern = 0;
  logic out_valid, out_ready = 0;
  logic [2:0] symbol_kind;
  logic [63:0] class_bits_0, class_bits_1, class_bits_2, class_bits_3;
  logic [7:0] operator_char;
  logic [9:0] symbol_index, partner_index;
  logic [3:0] error_code;
  logic last_of_run;

  int send_idle = 0, recv_idle = 0;
  token_scoreboard sb;

  always #4 clk = ~clk;

  regex_pattern_tokenizer u_dut (
    .clk, .rst, .excluded_byte_we, .excluded_byte, .in_valid, .in_ready,
    .pattern_byte, .end_of_pattern, .out_valid, .out_ready, .symbol_kind,
    .class_bits_0, .class_bits_1, .class_bits_2, .class_bits_3, .operator_char,
    .symbol_index, .partner_index, .error_code, .last_of_run
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_token({symbol_kind, class_bits_3, class_bits_2, class_bits_1, class_bits_0,
                      operator_char, symbol_index, partner_index, error_code, last_of_run});
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_byte(logic [7:0] b, bit last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    pattern_byte <= b;
    end_of_pattern <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic set_excluded(logic [7:0] v);
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    excluded_byte_we <= 1;
    excluded_byte <= v;
    @(negedge clk);
    excluded_byte_we <= 0;
    sb.excl = v;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] specials[12] = '{CH_BSL, CH_QUES, CH_STAR, CH_PLUS, CH_BAR, CH_DOT,
                                 CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_DASH, CH_D};
    int r = $urandom_range(99);
    if (r < 35) return specials[$urandom_range(11)];
    if (r < 45) return CH_W;
    if (r < 80) return 8'($urandom_range(CH_LA, CH_LZ));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pattern(int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] settings[4] = '{8'd0, 8'd255, 8'h61, 8'h5f};
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    set_excluded(8'h00);
    send_str("a(b)*\\d\\w[a-z-]?.+|");
    send_str("[]");
    send_str("[z-a]");
    send_str("x\\");
    send_str("[ab");
    send_str("((a)");
    send_str(")");
    send_str("]");
    send_byte(8'h00, 1);
    send_byte(8'hff, 1);
    for (int i = 0; i < 17; i++) send_byte(CH_LPAR, 0);
    send_byte(CH_RPAR, 1);
    for (int i = 0; i < 1025; i++) send_byte(CH_DOT, i == 1024);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 47 : 0;
      recv_idle = (ph == 0) ? 47 : (ph == 1) ? 31 : 0;
      for (int s = 0; s < 4; s++) begin
        set_excluded(settings[s]);
        if (s == 3) send_str("\\w[_]");
        for (int k = 0; k < 2; k++) begin
          send_pattern($urandom_range(1, 20));
        end
      end
    end
    set_excluded(8'($urandom_range(255)));
    send_str("[\\-]");
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/rpt_pkg.sv
rtl/rpt_stack_mem.sv
rtl/rpt_parser.sv
rtl/regex_pattern_tokenizer.sv
bench/tb_top.sv
